// ===== hw/rtl/fvtc_pkg.sv =====
package fvtc_pkg;

	localparam logic [15:0] SIG_GOOD    = 16'hAA55;
	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;

	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_BAD_SIG   = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV  = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW = 2'd3;

	localparam logic [1:0] TYPE_FAT12 = 2'd0;
	localparam logic [1:0] TYPE_FAT16 = 2'd1;
	localparam logic [1:0] TYPE_FAT32 = 2'd2;

	localparam int IN_W  = 176;
	localparam int OUT_W = 40;

	// Quotient bits of the two divider pipelines.
	localparam int ROOT_BITS = 22;
	localparam int CLUS_BITS = 32;

	typedef struct packed {
		logic                 bad_sig;
		logic                 zero_div;
		logic [ROOT_BITS-1:0] num;
		logic [15:0]          bps;
		logic [15:0]          rsvd;
		logic [7:0]           copies;
		logic [31:0]          fat_size;
		logic [31:0]          total;
		logic [7:0]           spc;
	} entry_t;

	typedef struct packed {
		logic                 bad_sig;
		logic                 zero_div;
		logic [15:0]          rem;
		logic [ROOT_BITS-1:0] w;
		logic [15:0]          bps;
		logic [15:0]          rsvd;
		logic [39:0]          prod;
		logic [31:0]          total;
		logic [7:0]           spc;
	} root_t;

	typedef struct packed {
		logic        bad_sig;
		logic        zero_div;
		logic [40:0] overhead;
		logic [31:0] total;
		logic [7:0]  spc;
	} ovh_t;

	typedef struct packed {
		logic                 bad_sig;
		logic                 zero_div;
		logic                 uflow;
		logic [7:0]           rem;
		logic [CLUS_BITS-1:0] w;
		logic [7:0]           spc;
	} clus_t;

endpackage

// ===== hw/rtl/fat_volume_type_classifier.sv =====
// Channel  | Direction | tdata fields, lowest bit first
// s_axis   | in        | signature 16, root_entry_count 16, bytes_per_sector 16,
//          |           | fat_size_short 16, fat_size_long 32, total_sectors_short 16,
//          |           | total_sectors_long 32, reserved_sectors 16, fat_copies 8,
//          |           | sectors_per_cluster 8 (176 bits)
// m_axis   | out       | status 2, fat_type 2, clusters 32, zero pad 4 (40 bits)
//
// One word is accepted every cycle unless the output stalls, and each gives one result.
// The pipeline is built around two restoring dividers, one quotient bit per stage:
// 22 stages for the root-directory sectors and 32 for the cluster count.
// Reset clears only the valid bits; payload registers are left alone.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall freezes every stage and nothing is lost or repeated.
module fat_volume_type_classifier (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// signature, root_entry_count, bytes_per_sector, fat_size_short,
	// fat_size_long, total_sectors_short, total_sectors_long, reserved_sectors,
	// fat_copies, sectors_per_cluster
	input  logic [fvtc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status, fat_type, clusters, zero pad
	output logic [fvtc_pkg::OUT_W-1:0] m_axis_tdata
);
	import fvtc_pkg::*;

	logic adv;

	logic   v_s1;
	entry_t e_s1;

	logic  rv_s [ROOT_BITS+1];
	root_t rd_s [ROOT_BITS+1];

	logic v_s3;
	ovh_t o_s3;

	logic  cv_s [CLUS_BITS+1];
	clus_t cd_s [CLUS_BITS+1];

	logic        out_v_q;
	logic [1:0]  status_q;
	logic [1:0]  type_q;
	logic [31:0] count_q;

	// Field unpacking.
	logic [15:0] in_sig, in_root, in_bps, in_fszs, in_tots, in_rsvd;
	logic [31:0] in_fszl, in_totl;
	logic [7:0]  in_copies, in_spc;

	assign in_sig    = s_axis_tdata[15:0];
	assign in_root   = s_axis_tdata[31:16];
	assign in_bps    = s_axis_tdata[47:32];
	assign in_fszs   = s_axis_tdata[63:48];
	assign in_fszl   = s_axis_tdata[95:64];
	assign in_tots   = s_axis_tdata[111:96];
	assign in_totl   = s_axis_tdata[143:112];
	assign in_rsvd   = s_axis_tdata[159:144];
	assign in_copies = s_axis_tdata[167:160];
	assign in_spc    = s_axis_tdata[175:168];

	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;

	// One restoring step of the root-directory divide.
	function automatic root_t root_step(input root_t r);
		root_t       n;
		logic [16:0] rs;
		logic        ge;
		begin
			n  = r;
			rs = {r.rem, r.w[ROOT_BITS-1]};
			ge = rs >= {1'b0, r.bps};
			n.rem = ge ? 16'(rs - {1'b0, r.bps}) : rs[15:0];
			n.w   = {r.w[ROOT_BITS-2:0], ge};
			return n;
		end
	endfunction

	// One restoring step of the cluster divide.
	function automatic clus_t clus_step(input clus_t c);
		clus_t      n;
		logic [8:0] rs;
		logic       ge;
		begin
			n  = c;
			rs = {c.rem, c.w[CLUS_BITS-1]};
			ge = rs >= {1'b0, c.spc};
			n.rem = ge ? 8'(rs - {1'b0, c.spc}) : rs[7:0];
			n.w   = {c.w[CLUS_BITS-2:0], ge};
			return n;
		end
	endfunction

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i <= ROOT_BITS; i++) rv_s[i] <= 1'b0;
			for (int i = 0; i <= CLUS_BITS; i++) cv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_axis_tvalid;
			rv_s[0] <= v_s1;
			for (int i = 0; i < ROOT_BITS; i++) rv_s[i+1] <= rv_s[i];
			v_s3    <= rv_s[ROOT_BITS];
			cv_s[0] <= v_s3;
			for (int i = 0; i < CLUS_BITS; i++) cv_s[i+1] <= cv_s[i];
			out_v_q <= cv_s[CLUS_BITS];
		end
	end

	// Payload path.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Entry: flags, long-form fallbacks and the root-directory numerator.
			e_s1.bad_sig  <= in_sig != SIG_GOOD;
			e_s1.zero_div <= (in_bps == 16'd0) || (in_spc == 8'd0);
			e_s1.num      <= {1'b0, in_root, 5'd0} + {6'd0, in_bps} - 22'd1;
			e_s1.bps      <= in_bps;
			e_s1.rsvd     <= in_rsvd;
			e_s1.copies   <= in_copies;
			e_s1.fat_size <= (in_fszs != 16'd0) ? {16'd0, in_fszs} : in_fszl;
			e_s1.total    <= (in_tots != 16'd0) ? {16'd0, in_tots} : in_totl;
			e_s1.spc      <= in_spc;

			// FAT area product and divider setup.
			rd_s[0].bad_sig  <= e_s1.bad_sig;
			rd_s[0].zero_div <= e_s1.zero_div;
			rd_s[0].rem      <= 16'd0;
			rd_s[0].w        <= e_s1.num;
			rd_s[0].bps      <= e_s1.bps;
			rd_s[0].rsvd     <= e_s1.rsvd;
			rd_s[0].prod     <= {32'd0, e_s1.copies} * {8'd0, e_s1.fat_size};
			rd_s[0].total    <= e_s1.total;
			rd_s[0].spc      <= e_s1.spc;
			for (int i = 0; i < ROOT_BITS; i++) rd_s[i+1] <= root_step(rd_s[i]);

			// Overhead sum kept at full width.
			o_s3.bad_sig  <= rd_s[ROOT_BITS].bad_sig;
			o_s3.zero_div <= rd_s[ROOT_BITS].zero_div;
			o_s3.overhead <= {25'd0, rd_s[ROOT_BITS].rsvd} + {1'b0, rd_s[ROOT_BITS].prod}
				+ {19'd0, rd_s[ROOT_BITS].w};
			o_s3.total    <= rd_s[ROOT_BITS].total;
			o_s3.spc      <= rd_s[ROOT_BITS].spc;

			// Underflow check and data sectors.
			cd_s[0].bad_sig  <= o_s3.bad_sig;
			cd_s[0].zero_div <= o_s3.zero_div;
			cd_s[0].uflow    <= o_s3.overhead > {9'd0, o_s3.total};
			cd_s[0].rem      <= 8'd0;
			cd_s[0].w        <= o_s3.total - o_s3.overhead[31:0];
			cd_s[0].spc      <= o_s3.spc;
			for (int i = 0; i < CLUS_BITS; i++) cd_s[i+1] <= clus_step(cd_s[i]);

			// Status precedence: signature, then zero divisor, then underflow.
			if (cd_s[CLUS_BITS].bad_sig) begin
				status_q <= ST_BAD_SIG;
			end else if (cd_s[CLUS_BITS].zero_div) begin
				status_q <= ST_ZERO_DIV;
			end else if (cd_s[CLUS_BITS].uflow) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= ST_VALID;
			end
			if (cd_s[CLUS_BITS].bad_sig || cd_s[CLUS_BITS].zero_div
				|| cd_s[CLUS_BITS].uflow) begin
				type_q  <= TYPE_FAT12;
				count_q <= 32'd0;
			end else begin
				count_q <= cd_s[CLUS_BITS].w;
				if (cd_s[CLUS_BITS].w < FAT12_LIMIT) begin
					type_q <= TYPE_FAT12;
				end else if (cd_s[CLUS_BITS].w < FAT16_LIMIT) begin
					type_q <= TYPE_FAT16;
				end else begin
					type_q <= TYPE_FAT32;
				end
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'd0, count_q, type_q, status_q};

endmodule

// ===== hw/rtl/fvtc_checker.sv =====
module fvtc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [fvtc_pkg::OUT_W-1:0] m_axis_tdata
);
	import fvtc_pkg::*;

	// A held result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// Input is only held back by a full, untaken output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// Failed volumes carry no type or count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_VALID |-> m_axis_tdata[39:2] == 38'd0)
		else $error("nonzero fields on failed volume");

	// Type agrees with cluster count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_VALID |->
		(m_axis_tdata[3:2] == TYPE_FAT12 && m_axis_tdata[35:4] < FAT12_LIMIT)
		|| (m_axis_tdata[3:2] == TYPE_FAT16 && m_axis_tdata[35:4] >= FAT12_LIMIT
			&& m_axis_tdata[35:4] < FAT16_LIMIT)
		|| (m_axis_tdata[3:2] == TYPE_FAT32 && m_axis_tdata[35:4] >= FAT16_LIMIT))
		else $error("FAT type does not match cluster count");

endmodule

bind fat_volume_type_classifier fvtc_checker u_fvtc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
